>>> hdl/pmps_pkg.sv
// Shared types, constants and codes of the polygon mask pixel select block.
package pmps_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int COORD_BITS   = 12;
  localparam int MIN_VERTICES = 3;
  localparam int RAY_END_X    = 5000;
  localparam int RGB_BITS     = 24;

  // Vertex index and vertex count widths.
  localparam int ADDR_BITS  = $clog2(MAX_VERTICES);
  localparam int COUNT_BITS = $clog2(MAX_VERTICES + 1);

  // Operand width of the orientation unit: wide enough for a coordinate and
  // for the ray end, plus a sign bit and one bit of growth for differences.
  localparam int RAY_BITS  = $clog2(RAY_END_X + 1);
  localparam int EXT_BITS  = (COORD_BITS > RAY_BITS) ? COORD_BITS : RAY_BITS;
  localparam int DIFF_BITS = EXT_BITS + 2;
  localparam int PROD_BITS = 2 * DIFF_BITS;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_TEST   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    TURN_COLL = 2'd0,
    TURN_CW   = 2'd1,
    TURN_CCW  = 2'd2
  } turn_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_ORIENT_P,
    ST_ORIENT_R,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]            kind;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic [RGB_BITS-1:0]   base_rgb;
    logic [RGB_BITS-1:0]   patch_rgb;
  } in_t;

  typedef struct packed {
    logic                inside_res;
    logic [RGB_BITS-1:0] out_rgb;
  } out_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } vertex_t;

endpackage

>>> hdl/polygon_mask_pixel_select.sv
// Top level of the polygon mask pixel select block: vertex store, edge sequencer and orientation unit.
//
// The block keeps a polygon of up to MAX_VERTICES vertices and tests pixels
// against it by casting a horizontal ray from the pixel to x = RAY_END_X.
// Input transactions arrive on in_valid_i / in_stall_o / in_data_i and are
// accepted on a clock edge where valid is high and stall is low. A clear or
// an append gives no result; an append to a full store is dropped. A test
// gives one result transaction on out_valid_o / out_stall_i / out_data_o:
// the inside flag, and the patch colour when inside, else the base colour.
// A test with three or more stored vertices loads the first vertex
// (ST_FIRST), then takes each edge through the single shared orientation
// unit, pixel side (ST_ORIENT_P) and then ray end side (ST_ORIENT_R), then
// moves the answer into the output register (ST_DONE). It leaves the edge
// walk early when the pixel lies in line with an edge that meets the ray.
// With fewer than three vertices it goes straight to ST_DONE and answers
// outside. The input is stalled until the result is loaded into the output
// register.
// Reset clears the vertex count and the output valid; only entries below
// the count are read. A stalled result stays in the output register and a
// finished test waits until that register has been emptied.
module polygon_mask_pixel_select
  import pmps_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  typedef logic signed [DIFF_BITS-1:0] sval_t;

  // Zero-extends a coordinate into the signed operand width.
  function automatic sval_t ext(input logic [COORD_BITS-1:0] v);
    ext = sval_t'({{(DIFF_BITS - COORD_BITS){1'b0}}, v});
  endfunction

  // True when point q lies in the bounding box of points u and w.
  function automatic logic in_box(input sval_t qx, input sval_t qy,
                                  input sval_t ux, input sval_t uy,
                                  input sval_t wx, input sval_t wy);
    logic x_ok;
    logic y_ok;
    x_ok   = (ux < wx) ? (qx >= ux && qx <= wx) : (qx >= wx && qx <= ux);
    y_ok   = (uy < wy) ? (qy >= uy && qy <= wy) : (qy >= wy && qy <= uy);
    in_box = x_ok && y_ok;
  endfunction

  localparam sval_t RAY_X = sval_t'(RAY_END_X);

  state_e                state_q, state_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [COUNT_BITS-1:0] idx_q, idx_d;
  logic                  parity_q, parity_d;
  logic                  inside_q, inside_d;
  logic                  out_valid_q, out_valid_d;
  turn_e                 s1_q;

  vertex_t               vtx_mem [MAX_VERTICES];
  vertex_t               rd_q;
  vertex_t               a_q;
  logic [ADDR_BITS-1:0]  rd_addr;

  logic [COORD_BITS-1:0] px_q, py_q;
  logic [RGB_BITS-1:0]   base_q, patch_q;
  out_t                  out_q;

  logic mem_we, capture, a_load, s1_load, load_out;

  // Shared orientation unit: sign of (by-ay)*(cx-bx) - (bx-ax)*(cy-by).
  sval_t                       ax, ay, bx, by, cx, cy, sx, sy;
  logic signed [PROD_BITS-1:0] prod_l, prod_r;
  logic signed [PROD_BITS:0]   cross_val;
  turn_e                       turn;

  always_comb begin
    ax = ext(a_q.x);
    ay = ext(a_q.y);
    bx = ext(rd_q.x);
    by = ext(rd_q.y);
    sx = ext(px_q);
    sy = ext(py_q);
    cx = (state_q == ST_ORIENT_R) ? RAY_X : sx;
    cy = sy;
    prod_l = (by - ay) * (cx - bx);
    prod_r = (bx - ax) * (cy - by);
    cross_val = {prod_l[PROD_BITS-1], prod_l} - {prod_r[PROD_BITS-1], prod_r};
    if (cross_val == '0) begin
      turn = TURN_COLL;
    end else if (!cross_val[PROD_BITS]) begin
      turn = TURN_CW;
    end else begin
      turn = TURN_CCW;
    end
  end

  // Edge decision. The ray is horizontal, so the orientations of the edge
  // ends against the ray reduce to comparisons with the pixel.
  turn_e s3, s4;
  logic  meet;
  logic  on_edge;

  always_comb begin
    if (RAY_X == sx || ay == sy) begin
      s3 = TURN_COLL;
    end else if ((RAY_X > sx) == (ay > sy)) begin
      s3 = TURN_CCW;
    end else begin
      s3 = TURN_CW;
    end
    if (RAY_X == sx || by == sy) begin
      s4 = TURN_COLL;
    end else if ((RAY_X > sx) == (by > sy)) begin
      s4 = TURN_CCW;
    end else begin
      s4 = TURN_CW;
    end
    on_edge = in_box(sx, sy, ax, ay, bx, by);
    meet = (s1_q != turn && s3 != s4) ||
           (s1_q == TURN_COLL && on_edge) ||
           (turn == TURN_COLL && in_box(RAY_X, sy, ax, ay, bx, by)) ||
           (s3 == TURN_COLL && in_box(ax, ay, sx, sy, RAY_X, sy)) ||
           (s4 == TURN_COLL && in_box(bx, by, sx, sy, RAY_X, sy));
  end

  assign in_stall_o = (state_q != ST_IDLE);

  // Sequencer: next state and control.
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    idx_d    = idx_q;
    parity_d = parity_q;
    inside_d = inside_q;
    mem_we   = 1'b0;
    capture  = 1'b0;
    a_load   = 1'b0;
    s1_load  = 1'b0;
    load_out = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_data_i.kind)
            KIND_CLEAR: begin
              count_d = '0;
            end
            KIND_APPEND: begin
              if (count_q < COUNT_BITS'(MAX_VERTICES)) begin
                mem_we  = 1'b1;
                count_d = count_q + 1'b1;
              end
            end
            KIND_TEST: begin
              capture  = 1'b1;
              idx_d    = '0;
              parity_d = 1'b0;
              if (count_q < COUNT_BITS'(MIN_VERTICES)) begin
                inside_d = 1'b0;
                state_d  = ST_DONE;
              end else begin
                state_d = ST_FIRST;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_FIRST: begin
        a_load  = 1'b1;
        idx_d   = COUNT_BITS'(1);
        state_d = ST_ORIENT_P;
      end
      ST_ORIENT_P: begin
        s1_load = 1'b1;
        state_d = ST_ORIENT_R;
      end
      ST_ORIENT_R: begin
        a_load = 1'b1;
        if (meet && s1_q == TURN_COLL) begin
          inside_d = on_edge;
          state_d  = ST_DONE;
        end else begin
          parity_d = parity_q ^ meet;
          if (idx_q == count_q) begin
            inside_d = parity_q ^ meet;
            state_d  = ST_DONE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_ORIENT_P;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // The closing edge wraps back to the first vertex.
  assign rd_addr = (idx_d == count_q) ? '0 : idx_d[ADDR_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      parity_q    <= 1'b0;
      inside_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      parity_q    <= parity_d;
      inside_q    <= inside_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Vertex store: one write port for appends, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      vtx_mem[count_q[ADDR_BITS-1:0]] <= '{x: in_data_i.pos_x, y: in_data_i.pos_y};
    end
    rd_q <= vtx_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (capture) begin
      px_q    <= in_data_i.pos_x;
      py_q    <= in_data_i.pos_y;
      base_q  <= in_data_i.base_rgb;
      patch_q <= in_data_i.patch_rgb;
    end
    if (a_load) begin
      a_q <= rd_q;
    end
    if (s1_load) begin
      s1_q <= turn;
    end
    if (load_out) begin
      out_q.inside_res <= inside_q;
      out_q.out_rgb    <= inside_q ? patch_q : base_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= COUNT_BITS'(MAX_VERTICES))
    else $error("vertex count beyond capacity");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ORIENT_P || state_q == ST_ORIENT_R) |->
      (idx_q >= COUNT_BITS'(1) && idx_q <= count_q))
    else $error("edge index outside the stored polygon");

  a_small_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && in_valid_i && in_data_i.kind == KIND_TEST &&
     count_q < COUNT_BITS'(MIN_VERTICES)) |=> (state_q == ST_DONE && !inside_q))
    else $error("test on a degenerate polygon did not answer outside");

  a_orient_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ORIENT_P |=> state_q == ST_ORIENT_R)
    else $error("orientation pair broken");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> ($stable(out_q) && out_valid_q))
    else $error("pending result overwritten");

endmodule

>>> sim/polygon_mask_pixel_select_test.sv
// Self-checking testbench of the polygon mask pixel select block, with its own ray casting predictor.
module polygon_mask_pixel_select_test;
  import pmps_pkg::*;

  // Kind code that the block must ignore; the package names only the used ones.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Accepted clear, append and test transactions per idling phase.
  localparam int ITEMS_PER_PHASE = 350;

  // Sized from the longest test and its load and output steps, this drain
  // covers any work still under way once the last expected result has come.
  localparam int DRAIN_CYCLES = 2 * MAX_VERTICES + 8;

  // Keeps a private copy of the vertex store, works out the answer of every
  // accepted test and compares the results of the block in order against it.
  class pixel_scoreboard;
    logic [COORD_BITS-1:0] corner_x [MAX_VERTICES];
    logic [COORD_BITS-1:0] corner_y [MAX_VERTICES];
    int unsigned           corner_count = 0;
    out_t                  answer_q [$];
    int unsigned           errors = 0;

    // Orientation of the turn a -> b -> c, from the sign of the cross product.
    function turn_e turn_of(longint ax, longint ay, longint bx, longint by,
                            longint cx, longint cy);
      longint v;
      v = (by - ay) * (cx - bx) - (bx - ax) * (cy - by);
      if (v == 0) return TURN_COLL;
      return (v > 0) ? TURN_CW : TURN_CCW;
    endfunction

    // True when b lies in the bounding box spanned by a and c.
    function bit in_box(longint ax, longint ay, longint bx, longint by,
                        longint cx, longint cy);
      longint xlo, xhi, ylo, yhi;
      xlo = (ax < cx) ? ax : cx;
      xhi = (ax < cx) ? cx : ax;
      ylo = (ay < cy) ? ay : cy;
      yhi = (ay < cy) ? cy : ay;
      return bx >= xlo && bx <= xhi && by >= ylo && by <= yhi;
    endfunction

    // Does the edge a-b meet the ray from the pixel to the far end of its row?
    function bit edge_meets_ray(longint ax, longint ay, longint bx, longint by,
                                longint px, longint py);
      turn_e s1, s2, s3, s4;
      longint rx;
      rx = RAY_END_X;
      s1 = turn_of(ax, ay, bx, by, px, py);
      s2 = turn_of(ax, ay, bx, by, rx, py);
      s3 = turn_of(px, py, rx, py, ax, ay);
      s4 = turn_of(px, py, rx, py, bx, by);
      if (s1 != s2 && s3 != s4) return 1'b1;
      if (s1 == TURN_COLL && in_box(ax, ay, px, py, bx, by)) return 1'b1;
      if (s2 == TURN_COLL && in_box(ax, ay, rx, py, bx, by)) return 1'b1;
      if (s3 == TURN_COLL && in_box(px, py, ax, ay, rx, py)) return 1'b1;
      if (s4 == TURN_COLL && in_box(px, py, bx, by, rx, py)) return 1'b1;
      return 1'b0;
    endfunction

    function bit pixel_inside(longint px, longint py);
      int unsigned crossings, j;
      longint ax, ay, bx, by;
      crossings = 0;
      if (corner_count < MIN_VERTICES) return 1'b0;
      for (int unsigned i = 0; i < corner_count; i++) begin
        j  = (i + 1 == corner_count) ? 0 : i + 1;
        ax = corner_x[i];
        ay = corner_y[i];
        bx = corner_x[j];
        by = corner_y[j];
        if (edge_meets_ray(ax, ay, bx, by, px, py)) begin
          // A pixel in line with a met edge is decided by that edge alone.
          if (turn_of(ax, ay, px, py, bx, by) == TURN_COLL)
            return in_box(ax, ay, px, py, bx, by);
          crossings++;
        end
      end
      return crossings[0];
    endfunction

    // Called for every transaction the block has accepted on its input.
    function void note_input(in_t item);
      out_t answer;
      case (item.kind)
        KIND_CLEAR: corner_count = 0;
        KIND_APPEND: begin
          if (corner_count < MAX_VERTICES) begin
            corner_x[corner_count] = item.pos_x;
            corner_y[corner_count] = item.pos_y;
            corner_count++;
          end
        end
        KIND_TEST: begin
          answer.inside_res = pixel_inside(item.pos_x, item.pos_y);
          answer.out_rgb    = answer.inside_res ? item.patch_rgb : item.base_rgb;
          answer_q.push_back(answer);
        end
        default: ;
      endcase
    endfunction

    // Called for every result transaction the block has delivered.
    function void check_result(out_t got);
      out_t want;
      if (answer_q.size() == 0) begin
        $error("unexpected result: inside_res %0d out_rgb %06h",
               got.inside_res, got.out_rgb);
        errors++;
        return;
      end
      want = answer_q.pop_front();
      if (got.inside_res !== want.inside_res) begin
        $error("inside_res: expected %0d, actual %0d", want.inside_res, got.inside_res);
        errors++;
      end
      if (got.out_rgb !== want.out_rgb) begin
        $error("out_rgb: expected %06h, actual %06h", want.out_rgb, got.out_rgb);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  // Idling percentages of the two sides, changed from phase to phase.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  // Accepted transactions that the block does not simply ignore.
  int unsigned items_sent;

  pixel_scoreboard board = new;

  // The polygon as the stimulus believes the block holds it, used to aim
  // test pixels at vertices, edges and vertex rows.
  vertex_t shape_q [$];

  polygon_mask_pixel_select DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // The receiver stalls at random; all signals are sampled just after the
  // rising edge, which still shows the values that the edge acted on.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Every result transaction is checked against the oldest answer waiting.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_result(out_data_o);
    end
  end

  // Offers one transaction, after a random gap, and holds it until accepted.
  task automatic send_op(input logic [1:0] kind, input logic [COORD_BITS-1:0] x,
                         input logic [COORD_BITS-1:0] y, input logic [RGB_BITS-1:0] base,
                         input logic [RGB_BITS-1:0] patch);
    in_t item;
    item.kind      = kind;
    item.pos_x     = x;
    item.pos_y     = y;
    item.base_rgb  = base;
    item.patch_rgb = patch;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_input(item);
    if (kind != KIND_UNUSED) items_sent++;
  endtask

  // One random polygon: a clear, one or two rounds of appends each followed
  // by a burst of tests, most aimed at the polygon. Now and then a lone noise
  // transaction of any kind is sent instead.
  task automatic run_episode();
    int unsigned           picks, sel, k, rounds;
    bit                    compact;
    logic [COORD_BITS-1:0] origin_x, origin_y, px, py;
    vertex_t               v, w;
    if ($urandom_range(9) == 0) begin
      send_op(2'($urandom), COORD_BITS'($urandom), COORD_BITS'($urandom),
              RGB_BITS'($urandom), RGB_BITS'($urandom));
      return;
    end
    send_op(KIND_CLEAR, COORD_BITS'($urandom), COORD_BITS'($urandom),
            RGB_BITS'($urandom), RGB_BITS'($urandom));
    shape_q.delete();
    // Compact polygons live in a 16 by 16 window, so that collinear
    // vertices, shared rows and pixels on edges turn up often.
    compact  = 1'($urandom_range(1));
    origin_x = COORD_BITS'($urandom_range(4080));
    origin_y = COORD_BITS'($urandom_range(4080));
    rounds   = $urandom_range(1, 2);
    repeat (rounds) begin
      sel = $urandom_range(9);
      if (sel == 0) picks = $urandom_range(0, 2);
      else if (sel == 1) picks = $urandom_range(14, 19);
      else picks = $urandom_range(3, 8);
      repeat (picks) begin
        if (compact) begin
          v.x = origin_x + COORD_BITS'($urandom_range(15));
          v.y = origin_y + COORD_BITS'($urandom_range(15));
        end else begin
          v.x = COORD_BITS'($urandom);
          v.y = COORD_BITS'($urandom);
        end
        send_op(KIND_APPEND, v.x, v.y, RGB_BITS'($urandom), RGB_BITS'($urandom));
        if (shape_q.size() < MAX_VERTICES) shape_q.push_back(v);
      end
      repeat ($urandom_range(1, 6)) begin
        sel = $urandom_range(99);
        px  = COORD_BITS'($urandom);
        py  = COORD_BITS'($urandom);
        if (shape_q.size() != 0 && sel >= 25) begin
          k = $urandom_range(shape_q.size() - 1);
          v = shape_q[k];
          w = shape_q[(k + 1) % shape_q.size()];
          if (sel < 50) begin
            px = v.x;
            py = v.y;
          end else if (sel < 70) begin
            px = COORD_BITS'((int'(v.x) + int'(w.x)) / 2);
            py = COORD_BITS'((int'(v.y) + int'(w.y)) / 2);
          end else if (sel < 85) begin
            py = v.y;
            if (compact) px = origin_x + COORD_BITS'($urandom_range(15));
          end else begin
            px = v.x + COORD_BITS'($urandom_range(2)) - 1'b1;
            py = v.y + COORD_BITS'($urandom_range(2)) - 1'b1;
          end
        end
        send_op(KIND_TEST, px, py, RGB_BITS'($urandom), RGB_BITS'($urandom));
      end
    end
  endtask

  initial begin
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    rst_ni         = 1'b0;
    items_sent     = 0;
    send_idle_pct  = 20;
    recv_stall_pct = 71;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. A test on an empty store, then a square grown one
    // vertex at a time so that one- and two-vertex tests answer outside.
    send_op(KIND_TEST,   12'd0,    12'd0,    24'h000000, 24'hFFFFFF);
    send_op(KIND_APPEND, 12'd100,  12'd100,  24'h000000, 24'h000000);
    send_op(KIND_TEST,   12'd2000, 12'd2000, 24'h123456, 24'hFFFFFF);
    send_op(KIND_APPEND, 12'd4000, 12'd100,  24'h000000, 24'h000000);
    send_op(KIND_TEST,   12'd100,  12'd100,  24'hFFFFFF, 24'h000000);
    send_op(KIND_APPEND, 12'd4000, 12'd4000, 24'h000000, 24'h000000);
    send_op(KIND_APPEND, 12'd100,  12'd4000, 24'h000000, 24'h000000);
    // Square complete: clearly inside, left of it, at the far corner of
    // the coordinate range, on a vertical edge, on the bottom edge (which
    // lies along the ray), on a vertex and at the origin.
    send_op(KIND_TEST,   12'd2000, 12'd2000, 24'hFFFFFF, 24'h000000);
    send_op(KIND_TEST,   12'd50,   12'd2000, 24'hFFFFFF, 24'h000000);
    send_op(KIND_TEST,   12'd4095, 12'd4095, 24'h000000, 24'hFFFFFF);
    send_op(KIND_TEST,   12'd100,  12'd2000, 24'h0000FF, 24'hFF0000);
    send_op(KIND_TEST,   12'd2000, 12'd100,  24'h00FF00, 24'h00FFFF);
    send_op(KIND_TEST,   12'd4000, 12'd4000, 24'hABCDEF, 24'h654321);
    send_op(KIND_TEST,   12'd0,    12'd0,    24'hFFFFFF, 24'hFFFFFF);
    // The unused kind must leave the store alone and give no result.
    send_op(KIND_UNUSED, 12'd4095, 12'd4095, 24'hFFFFFF, 24'hFFFFFF);
    send_op(KIND_TEST,   12'd3999, 12'd3999, 24'h000000, 24'hFFFFFF);
    // A triangle whose right vertex lies on the ray of a pixel inside it,
    // and pixels on that vertex and on the edge along x = 0.
    send_op(KIND_CLEAR,  12'd4095, 12'd4095, 24'hFFFFFF, 24'hFFFFFF);
    send_op(KIND_APPEND, 12'd0,    12'd0,    24'h000000, 24'h000000);
    send_op(KIND_APPEND, 12'd4095, 12'd2048, 24'h000000, 24'h000000);
    send_op(KIND_APPEND, 12'd0,    12'd4095, 24'h000000, 24'h000000);
    send_op(KIND_TEST,   12'd1000, 12'd2048, 24'h000000, 24'hFFFFFF);
    send_op(KIND_TEST,   12'd4095, 12'd2048, 24'h000000, 24'hFFFFFF);
    send_op(KIND_TEST,   12'd0,    12'd2048, 24'h000000, 24'hFFFFFF);
    send_op(KIND_CLEAR,  12'd0,    12'd0,    24'h000000, 24'h000000);
    send_op(KIND_TEST,   12'd1000, 12'd2048, 24'h000000, 24'hFFFFFF);

    // Random part in three phases: a slow receiver, then a slow sender,
    // then both sides at full rate.
    while (items_sent < ITEMS_PER_PHASE) run_episode();
    send_idle_pct  = 71;
    recv_stall_pct = 20;
    while (items_sent < 2 * ITEMS_PER_PHASE) run_episode();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (items_sent < 3 * ITEMS_PER_PHASE) run_episode();
    in_valid_i <= 1'b0;

    // Let every outstanding test finish, then watch for stray results.
    while (board.answer_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0 && board.answer_q.size() == 0) begin
      $display("polygon_mask_pixel_select: match");
    end else begin
      $display("polygon_mask_pixel_select: mismatch");
    end
    $finish;
  end

  // Watchdog: a run that does not finish in time counts as a mismatch.
  initial begin
    #4000000;
    $display("polygon_mask_pixel_select: mismatch");
    $finish;
  end

endmodule
